/* design/power_factor_ema_filter_macros.svh */
// Assertion macros shared by the power factor filter RTL.
// Expects clk_i and rst_ni in the scope of use.
`ifndef POWER_FACTOR_EMA_FILTER_MACROS_SVH
`define POWER_FACTOR_EMA_FILTER_MACROS_SVH

// Same-cycle implication.
`define PFEMA_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define PFEMA_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* design/pfema_pkg.sv */
// Package for the power factor filter: item types, register codes, constants.
// No dependencies.
package pfema_pkg;

  localparam int unsigned POWER_W = 24;
  localparam int unsigned PF_W    = 16;
  localparam int unsigned ALPHA_W = 16;
  localparam int unsigned DIV_QW  = 15;
  localparam int unsigned DIV_NW  = POWER_W + DIV_QW;
  localparam int unsigned CFG_IDX_W = 1;

  localparam logic signed [PF_W-1:0] PF_ONE     = 16'sd16384;
  localparam logic signed [PF_W-1:0] PF_NEG_ONE = -16'sd16384;

  localparam logic [POWER_W-1:0] MIN_APPARENT_RST = 24'd320;
  localparam logic [ALPHA_W-1:0] ALPHA_RST        = 16'd13107;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MIN_APPARENT = 1'b0,
    CFG_ALPHA        = 1'b1
  } cfg_reg_e;

  typedef struct packed {
    logic [1:0]                phase;
    logic signed [POWER_W-1:0] active_power;
    logic [POWER_W-1:0]        apparent_power;
  } pfema_in_t;

  typedef struct packed {
    logic signed [PF_W-1:0] filtered_pf;
    logic signed [PF_W-1:0] instant_pf;
    logic                   below_minimum;
  } pfema_out_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

/* design/pfema_div.sv */
// Radix-2 restoring divider, one quotient bit per cycle.
// Depends on pfema_pkg. Needs num_i < den_i * 2**DIV_QW.
module pfema_div (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  input  logic [pfema_pkg::DIV_NW-1:0]   num_i,
  input  logic [pfema_pkg::POWER_W-1:0]  den_i,
  output pfema_pkg::div_stat_t           stat_o,
  output logic [pfema_pkg::DIV_QW-1:0]   quot_o
);
  import pfema_pkg::*;

  localparam int unsigned CNT_W = $clog2(DIV_QW + 1);

  logic [POWER_W-1:0] rem_q, rem_d;
  logic [DIV_QW-1:0]  shf_q, shf_d;
  logic [POWER_W-1:0] den_q, den_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic               done_q, done_d;
  logic [POWER_W+1:0] trial;
  logic               borrow;

  assign trial  = {1'b0, rem_q, shf_q[DIV_QW-1]} - {2'b00, den_q};
  assign borrow = trial[POWER_W+1];

  always_comb begin
    rem_d  = rem_q;
    shf_d  = shf_q;
    den_d  = den_q;
    cnt_d  = cnt_q;
    done_d = 1'b0;
    if (start_i) begin
      rem_d = num_i[DIV_NW-1:DIV_QW];
      shf_d = num_i[DIV_QW-1:0];
      den_d = den_i;
      cnt_d = CNT_W'(DIV_QW);
    end else if (cnt_q != '0) begin
      rem_d  = borrow ? {rem_q[POWER_W-2:0], shf_q[DIV_QW-1]} : trial[POWER_W-1:0];
      shf_d  = {shf_q[DIV_QW-2:0], ~borrow};
      cnt_d  = cnt_q - 1'b1;
      done_d = (cnt_q == CNT_W'(1));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    shf_q <= shf_d;
    den_q <= den_d;
  end

  assign stat_o.busy = (cnt_q != '0);
  assign stat_o.done = done_q;
  assign quot_o      = shf_q;

endmodule

/* design/power_factor_ema_filter.sv */
// Per-phase power factor with first-order low-pass, top level.
// Depends on pfema_pkg, pfema_div and power_factor_ema_filter_macros.svh.
//
//   port group   direction  handshake              payload
//   in_*         in         in_valid_i/in_stall_o  pfema_in_t
//   out_*        out        out_valid_o/out_stall_i pfema_out_t
//   cfg_*        in         cfg_valid_i/cfg_ready_o cfg_index_i, cfg_data_i
//
// An item at or below threshold or with |active| >= apparent skips the divider;
// otherwise it passes the 15-step shared divider, then one multiply and one update.
// Reset sets every phase to 1.0 and both registers to their defaults.
// A stalled result waits in the output register; the next item may run meanwhile
// but its update waits there until the output register is free.
`include "power_factor_ema_filter_macros.svh"

module power_factor_ema_filter #(
  parameter int unsigned NUM_PHASES = 3
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  pfema_pkg::pfema_in_t              in_item_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output pfema_pkg::pfema_out_t             out_item_o,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [pfema_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [pfema_pkg::POWER_W-1:0]     cfg_data_i
);
  import pfema_pkg::*;

  localparam int unsigned IDX_W = (NUM_PHASES > 1) ? $clog2(NUM_PHASES) : 1;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_DIV  = 4'b0010,
    ST_MUL  = 4'b0100,
    ST_UPD  = 4'b1000
  } state_e;

  state_e state_q, state_d;

  logic [POWER_W-1:0]     min_app_q;
  logic [ALPHA_W-1:0]     alpha_q;
  logic signed [PF_W-1:0] store_q [NUM_PHASES];

  logic [IDX_W-1:0]       idx_q, idx_d;
  logic                   neg_q, neg_d;
  logic                   below_q, below_d;
  logic signed [PF_W-1:0] inst_q, inst_d;
  logic signed [32:0]     prod_q, prod_d;
  logic                   out_valid_q, out_valid_d;
  pfema_out_t             out_item_q, out_item_d;

  logic                   in_accept;
  logic                   in_neg;
  logic [POWER_W-1:0]     in_mag;
  logic                   in_below;
  logic                   in_big;
  logic [DIV_NW-1:0]      div_num;
  div_stat_t              div_stat;
  logic [DIV_QW-1:0]      div_quot;
  logic [DIV_QW-1:0]      q_clamped;
  logic                   div_start;

  logic signed [PF_W-1:0] old;
  logic signed [16:0]     diff;
  logic signed [33:0]     mul_full;
  logic signed [32:0]     rnd;
  logic signed [16:0]     step;
  logic signed [18:0]     sum;
  logic signed [PF_W-1:0] nxt;
  logic                   out_free;

  // configuration
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_app_q <= MIN_APPARENT_RST;
      alpha_q   <= ALPHA_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CFG_MIN_APPARENT: min_app_q <= cfg_data_i;
        CFG_ALPHA:        alpha_q   <= cfg_data_i[ALPHA_W-1:0];
        default:          ;
      endcase
    end
  end

  // input decode
  assign in_stall_o = (state_q != ST_IDLE);
  assign in_accept  = in_valid_i && !in_stall_o;
  assign in_neg     = in_item_i.active_power[POWER_W-1];
  assign in_mag     = in_neg ? (~in_item_i.active_power + 1'b1) : in_item_i.active_power;
  assign in_below   = !(in_item_i.apparent_power > min_app_q);
  assign in_big     = (in_mag >= in_item_i.apparent_power);
  assign div_num    = {1'b0, in_mag, {DIV_QW-1{1'b0}}}
                    + DIV_NW'(in_item_i.apparent_power[POWER_W-1:1]);
  assign div_start  = in_accept && !in_below && !in_big;

  pfema_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (in_item_i.apparent_power),
    .stat_o  (div_stat),
    .quot_o  (div_quot)
  );

  assign q_clamped = (div_quot > DIV_QW'(PF_ONE)) ? DIV_QW'(PF_ONE) : div_quot;

  // filter arithmetic
  assign old      = store_q[idx_q];
  assign diff     = $signed({inst_q[PF_W-1], inst_q}) - $signed({old[PF_W-1], old});
  assign mul_full = $signed({1'b0, alpha_q}) * diff;
  assign rnd      = prod_q + 33'sd32768;
  assign step     = rnd[32:16];
  assign sum      = $signed({{3{old[PF_W-1]}}, old}) + $signed({{2{step[16]}}, step});
  assign nxt      = (sum > 19'sd16384)  ? PF_ONE :
                    (sum < -19'sd16384) ? PF_NEG_ONE : sum[PF_W-1:0];
  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d     = state_q;
    idx_d       = idx_q;
    neg_d       = neg_q;
    below_d     = below_q;
    inst_d      = inst_q;
    prod_d      = prod_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_item_d  = out_item_q;
    case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          idx_d   = ({30'd0, in_item_i.phase} >= NUM_PHASES) ?
                    IDX_W'(NUM_PHASES - 1) : IDX_W'(in_item_i.phase);
          neg_d   = in_neg;
          below_d = in_below;
          if (in_below || in_big) begin
            inst_d  = (!in_below && in_neg) ? PF_NEG_ONE : PF_ONE;
            state_d = ST_MUL;
          end else begin
            state_d = ST_DIV;
          end
        end
      end
      ST_DIV: begin
        if (div_stat.done) begin
          inst_d  = neg_q ? -$signed({1'b0, q_clamped}) : $signed({1'b0, q_clamped});
          state_d = ST_MUL;
        end
      end
      ST_MUL: begin
        prod_d  = mul_full[32:0];
        state_d = ST_UPD;
      end
      ST_UPD: begin
        if (out_free) begin
          out_valid_d              = 1'b1;
          out_item_d.filtered_pf   = nxt;
          out_item_d.instant_pf    = inst_q;
          out_item_d.below_minimum = below_q;
          state_d                  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      for (int i = 0; i < NUM_PHASES; i++) begin
        store_q[i] <= PF_ONE;
      end
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      if (state_q == ST_UPD && out_free) begin
        store_q[idx_q] <= nxt;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q      <= idx_d;
    neg_q      <= neg_d;
    below_q    <= below_d;
    inst_q     <= inst_d;
    prod_q     <= prod_d;
    out_item_q <= out_item_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

  `PFEMA_ASSERT_IMP(a_div_done_in_div, div_stat.done, state_q == ST_DIV, "divider done outside DIV")
  `PFEMA_ASSERT_IMP(a_accept_div_idle, in_accept, !div_stat.busy, "item taken while divider busy")
  `PFEMA_ASSERT_NXT(a_accept_next, in_accept, state_q == ST_DIV || state_q == ST_MUL, "bad state after accept")
  `PFEMA_ASSERT_IMP(a_old_range, state_q == ST_MUL, old >= PF_NEG_ONE && old <= PF_ONE, "stored pf out of range")
  `PFEMA_ASSERT_IMP(a_inst_range, state_q == ST_MUL, inst_q >= PF_NEG_ONE && inst_q <= PF_ONE, "instant pf out of range")

endmodule
